### sv/hhpd_pkg.sv
// shared types and constants for the heading hold pid drive mixer
package hhpd_pkg;

  localparam int ERR_W   = 17;
  localparam int DELTA_W = 18;
  localparam int SPEED_W = 18;
  localparam int INTEG_W = 48;
  localparam int CORR_W  = 50;
  localparam int S100_W  = 25;
  localparam int MIX_W   = 51;

  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_TARGET_HEADING = 3'd3;
  localparam logic [2:0] REG_TARGET_SPEED   = 3'd4;
  localparam logic [2:0] REG_RAMP_STEP      = 3'd5;
  localparam logic [2:0] REG_DRIVE_MODE     = 3'd6;

  localparam logic signed [ERR_W-1:0] WRAP_LIMIT = 17'sd18000;
  localparam logic signed [ERR_W-1:0] WRAP_SPAN  = 17'sd36000;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;

  localparam logic signed [7:0]       SPEED_SCALE = 8'sd100;
  localparam logic signed [MIX_W-1:0] DRIVE_SAT   = 51'sd2585600;
  localparam logic [11:0]             DRIVE_RECIP = 12'd2622;
  localparam logic signed [7:0]       DRIVE_MAX   = 8'sd100;

  typedef enum logic [1:0] {
    MODE_PLUS     = 2'd0,
    MODE_MINUS    = 2'd1,
    MODE_SPIN     = 2'd2,
    MODE_ONE_SIDE = 2'd3
  } drive_mode_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_load_t;

endpackage

### sv/heading_hold_pid_drive_mixer.sv
// top level: config registers, six-stage pipe control and the three stage groups
// an input transfer is registered in stage s1 and moves through s2 to s6, which holds the output
// throughput: one item per cycle while the output is not stalled; every stage holds one item and moves on its own
// a stalled output only blocks stages that are full, bubbles are still filled
// reset clears the config registers, the integral, previous error, ramped speed
// and all stage valid flags
module heading_hold_pid_drive_mixer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [2:0]                         cfg_index,
  input  logic [15:0]                        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        heading,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [7:0]                  left_drive,
  output logic signed [7:0]                  right_drive,
  output logic signed [hhpd_pkg::ERR_W-1:0]  heading_error
);

  logic signed [15:0]    gain_p;
  logic signed [15:0]    gain_i;
  logic signed [15:0]    gain_d;
  logic [15:0]           target_heading;
  logic signed [7:0]     target_speed;
  logic signed [15:0]    ramp_step;
  hhpd_pkg::drive_mode_t drive_mode;

  logic                  v1, v2, v3, v4, v5;
  hhpd_pkg::stage_load_t ld;
  logic                  move6;

  logic signed [hhpd_pkg::ERR_W-1:0]   e_s1;
  logic signed [hhpd_pkg::DELTA_W-1:0] delta_s1;
  logic                                restart_s1;
  logic signed [hhpd_pkg::CORR_W-1:0]  corr_s4;
  logic signed [hhpd_pkg::S100_W-1:0]  s100_s4;
  logic signed [hhpd_pkg::ERR_W-1:0]   e_s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      target_heading <= '0;
      target_speed   <= '0;
      ramp_step      <= '0;
      drive_mode     <= hhpd_pkg::MODE_PLUS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hhpd_pkg::REG_GAIN_P:         gain_p         <= cfg_wdata;
        hhpd_pkg::REG_GAIN_I:         gain_i         <= cfg_wdata;
        hhpd_pkg::REG_GAIN_D:         gain_d         <= cfg_wdata;
        hhpd_pkg::REG_TARGET_HEADING: target_heading <= cfg_wdata;
        hhpd_pkg::REG_TARGET_SPEED:   target_speed   <= cfg_wdata[7:0];
        hhpd_pkg::REG_RAMP_STEP:      ramp_step      <= cfg_wdata;
        hhpd_pkg::REG_DRIVE_MODE:     drive_mode     <= hhpd_pkg::drive_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // a stage loads when the one before holds an item and it is empty or emptying
  always_comb begin
    move6    = out_valid && !out_stall;
    ld.s6    = v5 && (!out_valid || move6);
    ld.s5    = v4 && (!v5 || ld.s6);
    ld.s4    = v3 && (!v4 || ld.s5);
    ld.s3    = v2 && (!v3 || ld.s4);
    ld.s2    = v1 && (!v2 || ld.s3);
    in_stall = v1 && !ld.s2;
    ld.s1    = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= ld.s1 || (v1 && !ld.s2);
      v2        <= ld.s2 || (v2 && !ld.s3);
      v3        <= ld.s3 || (v3 && !ld.s4);
      v4        <= ld.s4 || (v4 && !ld.s5);
      v5        <= ld.s5 || (v5 && !ld.s6);
      out_valid <= ld.s6 || (out_valid && !move6);
    end
  end

  hhpd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .ld             (ld),
    .heading        (heading),
    .restart        (restart),
    .target_heading (target_heading),
    .e_s1           (e_s1),
    .delta_s1       (delta_s1),
    .restart_s1     (restart_s1)
  );

  hhpd_pid u_pid (
    .clk          (clk),
    .rst          (rst),
    .ld           (ld),
    .e_s1         (e_s1),
    .delta_s1     (delta_s1),
    .restart_s1   (restart_s1),
    .gain_p       (gain_p),
    .gain_i       (gain_i),
    .gain_d       (gain_d),
    .target_speed (target_speed),
    .ramp_step    (ramp_step),
    .corr_s4      (corr_s4),
    .s100_s4      (s100_s4),
    .e_s4         (e_s4)
  );

  hhpd_mix u_mix (
    .clk           (clk),
    .ld            (ld),
    .corr_s4       (corr_s4),
    .s100_s4       (s100_s4),
    .e_s4          (e_s4),
    .drive_mode    (drive_mode),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .heading_error (heading_error)
  );

`ifndef SYNTHESIS
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive >= -hhpd_pkg::DRIVE_MAX && left_drive <= hhpd_pkg::DRIVE_MAX &&
                   right_drive >= -hhpd_pkg::DRIVE_MAX && right_drive <= hhpd_pkg::DRIVE_MAX))
    else $error("drive outside percent range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && v5 && out_valid && out_stall))
    else $error("input stalled with a free stage");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_one_side_clamp: assert property (@(posedge clk) disable iff (rst)
    (ld.s6 && drive_mode == hhpd_pkg::MODE_ONE_SIDE) |=>
      (left_drive <= 0 && right_drive <= 0))
    else $error("one-side turn drove a side forward");
`endif

endmodule

### sv/hhpd_front.sv
// front stage: wrapped heading error and its change since the last tick
module hhpd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  hhpd_pkg::stage_load_t               ld,
  input  logic [15:0]                         heading,
  input  logic                                restart,
  input  logic [15:0]                         target_heading,
  output logic signed [hhpd_pkg::ERR_W-1:0]   e_s1,
  output logic signed [hhpd_pkg::DELTA_W-1:0] delta_s1,
  output logic                                restart_s1
);

  logic signed [hhpd_pkg::ERR_W-1:0]   prev_err;
  logic signed [hhpd_pkg::ERR_W-1:0]   diff;
  logic signed [hhpd_pkg::ERR_W-1:0]   err;
  logic signed [hhpd_pkg::ERR_W-1:0]   prev_base;
  logic signed [hhpd_pkg::DELTA_W-1:0] delta;

  always_comb begin
    diff      = $signed({1'b0, heading}) - $signed({1'b0, target_heading});
    err       = (diff > hhpd_pkg::WRAP_LIMIT) ? diff - hhpd_pkg::WRAP_SPAN : diff;
    prev_base = restart ? '0 : prev_err;
    delta     = $signed({err[hhpd_pkg::ERR_W-1], err})
              - $signed({prev_base[hhpd_pkg::ERR_W-1], prev_base});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (ld.s1) begin
      prev_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      e_s1       <= err;
      delta_s1   <= delta;
      restart_s1 <= restart;
    end
  end

endmodule

### sv/hhpd_pid.sv
// pid stages: gain products, speed ramp, saturating integral and correction sum
module hhpd_pid (
  input  logic                                clk,
  input  logic                                rst,
  input  hhpd_pkg::stage_load_t               ld,
  input  logic signed [hhpd_pkg::ERR_W-1:0]   e_s1,
  input  logic signed [hhpd_pkg::DELTA_W-1:0] delta_s1,
  input  logic                                restart_s1,
  input  logic signed [15:0]                  gain_p,
  input  logic signed [15:0]                  gain_i,
  input  logic signed [15:0]                  gain_d,
  input  logic signed [7:0]                   target_speed,
  input  logic signed [15:0]                  ramp_step,
  output logic signed [hhpd_pkg::CORR_W-1:0]  corr_s4,
  output logic signed [hhpd_pkg::S100_W-1:0]  s100_s4,
  output logic signed [hhpd_pkg::ERR_W-1:0]   e_s4
);

  // stage 2
  logic signed [32:0]                     p_s2;
  logic signed [32:0]                     i_s2;
  logic signed [33:0]                     dd_s2;
  logic signed [hhpd_pkg::SPEED_W-1:0]    speed_s2;
  logic                                   restart_s2;
  logic signed [hhpd_pkg::ERR_W-1:0]      e_s2;
  logic signed [hhpd_pkg::SPEED_W-1:0]    ramped;
  logic signed [hhpd_pkg::SPEED_W-1:0]    ramp_base;
  logic signed [hhpd_pkg::SPEED_W-1:0]    ramped_next;
  logic signed [15:0]                     tgt_fixed;
  logic [hhpd_pkg::SPEED_W-1:0]           base_mag;
  logic [16:0]                            tgt_mag;

  // stage 3
  logic signed [hhpd_pkg::INTEG_W-1:0]    integral;
  logic signed [hhpd_pkg::INTEG_W-1:0]    integ_base;
  logic signed [hhpd_pkg::INTEG_W:0]      integ_sum;
  logic signed [hhpd_pkg::INTEG_W-1:0]    integral_next;
  logic signed [hhpd_pkg::INTEG_W-1:0]    integ_s3;
  logic signed [34:0]                     pd_s3;
  logic signed [hhpd_pkg::S100_W-1:0]     s100_s3;
  logic signed [hhpd_pkg::ERR_W-1:0]      e_s3;

  always_comb begin
    ramp_base   = restart_s1 ? '0 : ramped;
    tgt_fixed   = {target_speed, 8'b0};
    base_mag    = ramp_base[hhpd_pkg::SPEED_W-1] ? 18'(-ramp_base) : 18'(ramp_base);
    tgt_mag     = tgt_fixed[15] ? 17'(-$signed({tgt_fixed[15], tgt_fixed}))
                                : 17'({tgt_fixed[15], tgt_fixed});
    ramped_next = (base_mag < {1'b0, tgt_mag})
                ? ramp_base + $signed({{2{ramp_step[15]}}, ramp_step})
                : ramp_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramped <= '0;
    end else if (ld.s2) begin
      ramped <= ramped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      p_s2       <= gain_p * e_s1;
      i_s2       <= gain_i * e_s1;
      dd_s2      <= gain_d * delta_s1;
      speed_s2   <= ramped_next;
      restart_s2 <= restart_s1;
      e_s2       <= e_s1;
    end
  end

  always_comb begin
    integ_base = restart_s2 ? '0 : integral;
    integ_sum  = $signed({integ_base[hhpd_pkg::INTEG_W-1], integ_base})
               + $signed({{16{i_s2[32]}}, i_s2});
    if (integ_sum[hhpd_pkg::INTEG_W] != integ_sum[hhpd_pkg::INTEG_W-1]) begin
      integral_next = integ_sum[hhpd_pkg::INTEG_W] ? hhpd_pkg::INTEG_MIN
                                                   : hhpd_pkg::INTEG_MAX;
    end else begin
      integral_next = integ_sum[hhpd_pkg::INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (ld.s3) begin
      integral <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      integ_s3 <= integral_next;
      pd_s3    <= $signed({{2{p_s2[32]}}, p_s2}) + $signed({dd_s2[33], dd_s2});
      s100_s3  <= speed_s2 * hhpd_pkg::SPEED_SCALE;
      e_s3     <= e_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      corr_s4 <= $signed({{2{integ_s3[hhpd_pkg::INTEG_W-1]}}, integ_s3})
               + $signed({{15{pd_s3[34]}}, pd_s3});
      s100_s4 <= s100_s3;
      e_s4    <= e_s3;
    end
  end

endmodule

### sv/hhpd_mix.sv
// mixer stages: mode mix, one-side clamp, scale to percent and saturate
module hhpd_mix (
  input  logic                               clk,
  input  hhpd_pkg::stage_load_t              ld,
  input  logic signed [hhpd_pkg::CORR_W-1:0] corr_s4,
  input  logic signed [hhpd_pkg::S100_W-1:0] s100_s4,
  input  logic signed [hhpd_pkg::ERR_W-1:0]  e_s4,
  input  hhpd_pkg::drive_mode_t              drive_mode,
  output logic signed [7:0]                  left_drive,
  output logic signed [7:0]                  right_drive,
  output logic signed [hhpd_pkg::ERR_W-1:0]  heading_error
);

  typedef struct packed {
    logic        hi;
    logic        lo;
    logic        neg;
    logic [11:0] x;
  } side_t;

  function automatic side_t prep(input logic signed [hhpd_pkg::MIX_W-1:0] num);
    side_t                      r;
    logic [hhpd_pkg::MIX_W-1:0] m;
    m     = num[hhpd_pkg::MIX_W-1] ? 51'(-num) : 51'(num);
    r.hi  = num >= hhpd_pkg::DRIVE_SAT;
    r.lo  = num <= -hhpd_pkg::DRIVE_SAT;
    r.neg = num[hhpd_pkg::MIX_W-1];
    r.x   = m[21:10];
    return r;
  endfunction

  // divide by 25600: drop ten bits, then times 2622 over 65536 for the 25
  function automatic logic signed [7:0] scale(input side_t s);
    logic [23:0]        prod;
    logic signed [7:0]  q;
    logic signed [7:0]  d;
    prod = {12'b0, s.x} * {12'b0, hhpd_pkg::DRIVE_RECIP};
    q    = $signed(prod[23:16]);
    if (s.hi) begin
      d = hhpd_pkg::DRIVE_MAX;
    end else if (s.lo) begin
      d = -hhpd_pkg::DRIVE_MAX;
    end else begin
      d = s.neg ? -q : q;
    end
    return d;
  endfunction

  logic signed [hhpd_pkg::MIX_W-1:0] c;
  logic signed [hhpd_pkg::MIX_W-1:0] s;
  logic signed [hhpd_pkg::MIX_W-1:0] left_num;
  logic signed [hhpd_pkg::MIX_W-1:0] right_num;
  side_t                             left_s5;
  side_t                             right_s5;
  logic signed [hhpd_pkg::ERR_W-1:0] e_s5;

  always_comb begin
    c = $signed({corr_s4[hhpd_pkg::CORR_W-1], corr_s4});
    s = $signed({{26{s100_s4[hhpd_pkg::S100_W-1]}}, s100_s4});
    case (drive_mode)
      hhpd_pkg::MODE_PLUS: begin
        left_num  = s + c;
        right_num = s - c;
      end
      hhpd_pkg::MODE_MINUS: begin
        left_num  = -s + c;
        right_num = -s - c;
      end
      hhpd_pkg::MODE_SPIN: begin
        left_num  = c;
        right_num = -c;
      end
      hhpd_pkg::MODE_ONE_SIDE: begin
        left_num  = -s - c;
        right_num = -s + c;
        if (left_num > 0) begin
          left_num = '0;
        end
        if (right_num > 0) begin
          right_num = '0;
        end
      end
      default: begin
        left_num  = '0;
        right_num = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      left_s5  <= prep(left_num);
      right_s5 <= prep(right_num);
      e_s5     <= e_s4;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s6) begin
      left_drive    <= scale(left_s5);
      right_drive   <= scale(right_s5);
      heading_error <= e_s5;
    end
  end

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for heading_hold_pid_drive_mixer with its own drive predictor
module tb_top;

  localparam int          LIMIT_CYCLES = 400_000;
  localparam int          INTEG_RUN    = 60;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          TAIL_CYCLES  = 10;
  localparam logic [2:0]  REG_SPARE    = 3'd7;

  typedef struct {
    logic signed [7:0]                 left_pct;
    logic signed [7:0]                 right_pct;
    logic signed [hhpd_pkg::ERR_W-1:0] err;
  } drive_result_t;

  class drive_checker;
    localparam longint DRIVE_SCALE = 25600;

    logic signed [15:0]    gain_p = '0;
    logic signed [15:0]    gain_i = '0;
    logic signed [15:0]    gain_d = '0;
    logic [15:0]           target_heading = '0;
    logic signed [7:0]     target_speed = '0;
    logic signed [15:0]    ramp_step = '0;
    hhpd_pkg::drive_mode_t mode = hhpd_pkg::MODE_PLUS;

    longint integ = 0;
    longint prev_err = 0;
    longint speed = 0;

    drive_result_t pending_drives[$];
    int errors = 0;

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        hhpd_pkg::REG_GAIN_P:         gain_p = data;
        hhpd_pkg::REG_GAIN_I:         gain_i = data;
        hhpd_pkg::REG_GAIN_D:         gain_d = data;
        hhpd_pkg::REG_TARGET_HEADING: target_heading = data;
        hhpd_pkg::REG_TARGET_SPEED:   target_speed = data[7:0];
        hhpd_pkg::REG_RAMP_STEP:      ramp_step = data;
        hhpd_pkg::REG_DRIVE_MODE:     mode = hhpd_pkg::drive_mode_t'(data[1:0]);
        default: ;
      endcase
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function logic signed [7:0] to_percent(longint num);
      longint d;
      d = num / DRIVE_SCALE;
      if (d > longint'(hhpd_pkg::DRIVE_MAX)) d = longint'(hhpd_pkg::DRIVE_MAX);
      if (d < -longint'(hhpd_pkg::DRIVE_MAX)) d = -longint'(hhpd_pkg::DRIVE_MAX);
      return d[7:0];
    endfunction

    function void note_heading(logic [15:0] h, logic rs);
      longint e, corr, s, l, r;
      drive_result_t want;
      if (rs) begin
        integ = 0;
        prev_err = 0;
        speed = 0;
      end
      if (magnitude(speed) < magnitude(longint'(target_speed) * 256))
        speed += longint'(ramp_step);
      e = longint'(h) - longint'(target_heading);
      if (e > longint'(hhpd_pkg::WRAP_LIMIT)) e -= longint'(hhpd_pkg::WRAP_SPAN);
      integ += longint'(gain_i) * e;
      if (integ > longint'(hhpd_pkg::INTEG_MAX)) integ = longint'(hhpd_pkg::INTEG_MAX);
      if (integ < longint'(hhpd_pkg::INTEG_MIN)) integ = longint'(hhpd_pkg::INTEG_MIN);
      corr = longint'(gain_p) * e + integ + longint'(gain_d) * (e - prev_err);
      s = speed * 100;
      case (mode)
        hhpd_pkg::MODE_PLUS: begin
          l = s + corr;
          r = s - corr;
        end
        hhpd_pkg::MODE_MINUS: begin
          l = -s + corr;
          r = -s - corr;
        end
        hhpd_pkg::MODE_SPIN: begin
          l = corr;
          r = -corr;
        end
        default: begin
          l = -s - corr;
          r = -s + corr;
          if (l > 0) l = 0;
          if (r > 0) r = 0;
        end
      endcase
      prev_err = e;
      want.left_pct  = to_percent(l);
      want.right_pct = to_percent(r);
      want.err       = e[hhpd_pkg::ERR_W-1:0];
      pending_drives.push_back(want);
    endfunction

    function void report(string what, longint exp_val, longint got_val);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
    endfunction

    function void check_drive(logic signed [7:0] l, logic signed [7:0] r,
                              logic signed [hhpd_pkg::ERR_W-1:0] e);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        report("result with none pending, heading_error", 0, e);
        return;
      end
      want = pending_drives.pop_front();
      if (l !== want.left_pct) report("left_drive", want.left_pct, l);
      if (r !== want.right_pct) report("right_drive", want.right_pct, r);
      if (e !== want.err) report("heading_error", want.err, e);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [15:0] heading;
  logic restart;
  logic out_valid;
  logic out_stall;
  logic signed [7:0] left_drive;
  logic signed [7:0] right_drive;
  logic signed [hhpd_pkg::ERR_W-1:0] heading_error;

  drive_checker ck;
  int send_pct = 0;
  int recv_pct = 0;
  int stall_left = 0;
  bit hold_req = 1'b0;

  heading_hold_pid_drive_mixer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .heading       (heading),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .heading_error (heading_error)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait(int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 12)) : 0;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 25;
      default: return 60;
    endcase
  endfunction

  function automatic logic [15:0] draw_gain();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'($urandom);
      4: return 16'($urandom_range(0, 4096) - 2048);
      default: return 16'($urandom_range(0, 128) - 64);
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    case ($urandom_range(0, 19))
      0: return 16'($urandom);
      1: return 16'd0;
      2: return 16'd35999;
      3: return 16'(ck.target_heading + 16'd18000 + 16'($urandom_range(0, 1)));
      default: return 16'($urandom_range(0, 35999));
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ck.set_reg(idx, data);
  endtask

  task automatic setup(input logic [15:0] gp, input logic [15:0] gi, input logic [15:0] gd,
                       input logic [15:0] th, input logic [7:0] ts, input logic [15:0] step,
                       input hhpd_pkg::drive_mode_t m);
    write_reg(hhpd_pkg::REG_GAIN_P, gp);
    write_reg(hhpd_pkg::REG_GAIN_I, gi);
    write_reg(hhpd_pkg::REG_GAIN_D, gd);
    write_reg(hhpd_pkg::REG_TARGET_HEADING, th);
    write_reg(hhpd_pkg::REG_TARGET_SPEED, {{8{ts[7]}}, ts});
    write_reg(hhpd_pkg::REG_RAMP_STEP, step);
    write_reg(hhpd_pkg::REG_DRIVE_MODE, {14'd0, m});
  endtask

  task automatic random_setup();
    logic [15:0] th;
    logic [7:0]  ts;
    logic [15:0] step;
    case ($urandom_range(0, 9))
      0: th = 16'd0;
      1: th = 16'd35999;
      2: th = 16'($urandom);
      default: th = 16'($urandom_range(0, 35999));
    endcase
    case ($urandom_range(0, 6))
      0: ts = 8'sd100;
      1: ts = -8'sd100;
      2: ts = 8'($urandom);
      3: ts = 8'd0;
      default: ts = 8'($urandom_range(0, 200) - 100);
    endcase
    case ($urandom_range(0, 7))
      0: step = 16'h7FFF;
      1: step = 16'h8000;
      2: step = 16'($urandom);
      3: step = 16'd0;
      default: step = 16'($urandom_range(0, 1200) - 600);
    endcase
    setup(draw_gain(), draw_gain(), draw_gain(), th, ts, step,
          hhpd_pkg::drive_mode_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
  endtask

  // returns at the edge of the transfer with in_valid still high
  task automatic send_tick(input logic [15:0] h, input logic rs);
    int gap;
    gap = draw_wait(send_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    heading  <= h;
    restart  <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ck.note_heading(h, rs);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ck.pending_drives.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ck.check_drive(left_drive, right_drive, heading_error);
      stall_left = draw_wait(recv_pct);
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req   = 1'b0;
        stall_left = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    ck = new();
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    heading   = '0;
    restart   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset values
    send_tick(16'd0, 1'b1);
    send_tick(16'd35999, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    drain();

    // wrap just above half a turn, ramp overshoot in one step
    setup(16'sd256, 16'sd128, -16'sd512, 16'd0, 8'sd100, 16'sh7FFF, hhpd_pkg::MODE_PLUS);
    send_tick(16'd18000, 1'b0);
    send_tick(16'd18001, 1'b0);
    send_tick(16'd35999, 1'b0);
    send_tick(16'd0, 1'b0);
    drain();

    // step against the target sign moves the speed away
    setup(16'sd16, 16'sd2, 16'sd8, 16'd0, -8'sd100, 16'sd200, hhpd_pkg::MODE_MINUS);
    send_tick(16'd9000, 1'b1);
    send_tick(16'd27000, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    drain();

    // turn in place, no low-side wrap
    setup(16'sh7FFF, 16'sh8000, 16'sh8000, 16'd35999, 8'sd50, -16'sd3000,
          hhpd_pkg::MODE_SPIN);
    send_tick(16'd0, 1'b1);
    send_tick(16'd35999, 1'b0);
    drain();

    // one-side turn with out-of-range target and speed, spare index ignored
    setup(16'sh7FFF, 16'sd1, 16'sh8000, 16'hFFFF, 8'h80, 16'sh8000,
          hhpd_pkg::MODE_ONE_SIDE);
    write_reg(REG_SPARE, 16'hFFFF);
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd100, 1'b0);
    drain();

    setup(-16'sd40, 16'sd3, 16'sd20, 16'd18000, 8'sd60, 16'sd9000, hhpd_pkg::MODE_ONE_SIDE);
    send_tick(16'd18000, 1'b1);
    send_tick(16'd0, 1'b0);
    send_tick(16'd35999, 1'b0);
    drain();

    for (int p = 0; p < 12; p++) begin
      random_setup();
      send_pct = pick_pct();
      recv_pct = pick_pct();
      if (p % 5 == 2) begin
        send_pct = 0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < 150; i++)
        send_tick(pick_heading(), $urandom_range(0, 24) == 0);
      drain();
    end

    // integral pushed with the largest gain and error in both directions
    send_pct = 0;
    recv_pct = 0;
    for (int k = 0; k < 2; k++) begin
      setup(16'd0, (k == 0) ? 16'h8000 : 16'h7FFF, 16'd0, 16'hFFFF, 8'd0, 16'd0,
            hhpd_pkg::MODE_PLUS);
      send_tick(16'd0, 1'b1);
      repeat (INTEG_RUN) send_tick(16'd0, 1'b0);
      drain();
    end

    if (ck.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
